### rtl/core/assert_macros.svh
// Assertion macros shared by the regulator RTL.
// Clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge out of reset.
`define AST_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define AST_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/mvpr_pkg.sv
// Package for the mixing valve pulse regulator: word types, codes, constants.
// No dependencies; used by every module of the block.
package mvpr_pkg;

  localparam int TEMP_W     = 16;
  localparam int TRAVEL_W   = 10;
  localparam int HOMING_W   = TRAVEL_W + 1;
  localparam int PCT_W      = 7;
  localparam int INTERVAL_W = 22;
  localparam int PULSE_S_W  = 8;
  localparam int CHECK_S_W  = 12;
  localparam int CODE_W     = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // divider: percent numerator = count * 100, count < full travel
  localparam int DIV_N_W    = 17;
  localparam int DIV_D_W    = TRAVEL_W;
  localparam int DIV_CNT_W  = 5;

  localparam int MS_PER_PULSE_S = 1500;
  localparam int MS_PER_S       = 1000;
  localparam int PCT_FULL       = 100;
  localparam int CHECK_MAX_S    = 3600;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FULL_TRAVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REST_CLOSED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_S     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_S     = 3'd5;

  // register reset values
  localparam logic [TRAVEL_W-1:0]  RST_FULL_TRAVEL = 10'd100;
  localparam logic                 RST_REST_CLOSED = 1'b1;
  localparam logic [TRAVEL_W-1:0]  RST_BAND        = 10'd10;
  localparam logic [TRAVEL_W-1:0]  RST_RISE_LIMIT  = 10'd3;
  localparam logic [PULSE_S_W-1:0] RST_PULSE_S     = 8'd1;
  localparam logic [CHECK_S_W-1:0] RST_CHECK_S     = 12'd60;
  localparam logic [INTERVAL_W-1:0] RST_INTERVAL   = 22'd60000;

  // enable_state codes
  localparam logic [CODE_W-1:0] EN_OFF   = 2'd0;
  localparam logic [CODE_W-1:0] EN_ON    = 2'd1;

  // pulse_command codes
  localparam logic [CODE_W-1:0] CMD_NONE  = 2'd0;
  localparam logic [CODE_W-1:0] CMD_OPEN  = 2'd1;
  localparam logic [CODE_W-1:0] CMD_CLOSE = 2'd2;

  // point_status codes
  localparam logic [CODE_W-1:0] STAT_OFF = 2'd0;
  localparam logic [CODE_W-1:0] STAT_REG = 2'd1;
  localparam logic [CODE_W-1:0] STAT_ERR = 2'd2;

  typedef struct packed {
    logic signed [TEMP_W-1:0] measured_temp;
    logic signed [TEMP_W-1:0] target_temp;
    logic [CODE_W-1:0]        enable_state;
    logic                     valve_busy;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0]     pulse_command;
    logic [PCT_W-1:0]      open_percent;
    logic [CODE_W-1:0]     point_status;
    logic [INTERVAL_W-1:0] next_interval_ms;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic div_start;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

### rtl/core/mvpr_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on mvpr_pkg for widths.
`include "assert_macros.svh"

module mvpr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mvpr_pkg::DIV_N_W-1:0]  dividend,
  input  logic [mvpr_pkg::DIV_D_W-1:0]  divisor,
  output logic [mvpr_pkg::DIV_N_W-1:0]  quotient,
  output logic                          done
);

  localparam logic [mvpr_pkg::DIV_CNT_W-1:0] LAST_STEP =
    mvpr_pkg::DIV_CNT_W'(mvpr_pkg::DIV_N_W - 1);

  logic                              busy_r;
  logic                              done_r;
  logic [mvpr_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [mvpr_pkg::DIV_N_W-1:0]      quo_r, quo_nxt;
  logic [mvpr_pkg::DIV_D_W-1:0]      rem_r, rem_nxt;
  logic [mvpr_pkg::DIV_D_W-1:0]      den_r;
  logic [mvpr_pkg::DIV_D_W:0]        trial;
  logic                              qbit;

  // dividend bits shift out of quo_r as quotient bits shift in
  always_comb begin
    trial = {rem_r, quo_r[mvpr_pkg::DIV_N_W-1]};
    qbit  = (trial >= {1'b0, den_r});
    if (qbit) begin
      rem_nxt = mvpr_pkg::DIV_D_W'(trial - {1'b0, den_r});
    end else begin
      rem_nxt = trial[mvpr_pkg::DIV_D_W-1:0];
    end
    quo_nxt = {quo_r[mvpr_pkg::DIV_N_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

  `AST_NEXT(a_div_starts, start, busy_r, "divider did not start")
  `AST_IMPLY(a_div_done_after_busy, done_r, $past(busy_r), "divider done without a run")

endmodule

### rtl/core/mvpr_datapath.sv
// Datapath: configuration registers, regulator state, interval and percent
// computation, output word register. Depends on mvpr_pkg and mvpr_div.
`include "assert_macros.svh"

module mvpr_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mvpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mvpr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  mvpr_pkg::in_word_t                in_data,
  input  mvpr_pkg::ctrl_cmd_t               cmd,
  output mvpr_pkg::dp_status_t              status,
  output mvpr_pkg::out_word_t               out_data
);

  localparam int TW = mvpr_pkg::TRAVEL_W;
  localparam int HW = mvpr_pkg::HOMING_W;
  localparam int XW = mvpr_pkg::TEMP_W + 2;   // room for exact differences
  localparam int IW = mvpr_pkg::INTERVAL_W;
  localparam int SW = 19;                     // pulse_seconds * 1500

  typedef enum logic [1:0] {PCT_KEEP, PCT_FIXED, PCT_DIV} pct_mode_t;

  // configuration
  logic [TW-1:0]                    ftp_r;
  logic                             rest_r;
  logic [TW-1:0]                    band_r;
  logic [TW-1:0]                    rise_r;
  logic [mvpr_pkg::PULSE_S_W-1:0]   ps_r;
  logic [mvpr_pkg::CHECK_S_W-1:0]   cs_r;

  // regulator state
  logic signed [HW-1:0]             homing_r, homing_nxt;
  logic [TW-1:0]                    pos_r, pos_nxt;
  logic signed [mvpr_pkg::TEMP_W-1:0] prev_r;
  logic [mvpr_pkg::PCT_W-1:0]       pct_held_r;
  logic [IW-1:0]                    interval_r, interval_nxt;

  // per-word results
  mvpr_pkg::in_word_t               in_r;
  logic [mvpr_pkg::CODE_W-1:0]      cmd_r, cmd_nxt;
  logic [mvpr_pkg::CODE_W-1:0]      stat_r, stat_nxt;
  pct_mode_t                        pct_mode_r, pct_mode_nxt;
  logic [mvpr_pkg::PCT_W-1:0]       pct_fixed_r, pct_fixed_nxt;
  logic [TW-1:0]                    div_num_r, div_num_nxt;
  mvpr_pkg::out_word_t              out_r;

  logic [mvpr_pkg::PULSE_S_W-1:0]   ps_eff;
  logic [mvpr_pkg::CHECK_S_W-1:0]   cs_eff;
  logic [SW-1:0]                    short_ms;
  logic [IW-1:0]                    long_ms, short_pick;

  logic signed [XW-1:0]             t_x, tgt_x, prev_x, h_x, r_x, d_x, nd_x;
  logic signed [HW-1:0]             ftp_s, pnum;
  logic                             on, busy, pct_from_num, open_ok, close_ok;
  logic [mvpr_pkg::PCT_W-1:0]       pct_final;
  logic [mvpr_pkg::DIV_N_W-1:0]     quotient;
  logic                             div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ftp_r  <= mvpr_pkg::RST_FULL_TRAVEL;
      rest_r <= mvpr_pkg::RST_REST_CLOSED;
      band_r <= mvpr_pkg::RST_BAND;
      rise_r <= mvpr_pkg::RST_RISE_LIMIT;
      ps_r   <= mvpr_pkg::RST_PULSE_S;
      cs_r   <= mvpr_pkg::RST_CHECK_S;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mvpr_pkg::REG_FULL_TRAVEL: ftp_r  <= cfg_wdata[TW-1:0];
        mvpr_pkg::REG_REST_CLOSED: rest_r <= cfg_wdata[0];
        mvpr_pkg::REG_BAND:        band_r <= cfg_wdata[TW-1:0];
        mvpr_pkg::REG_RISE_LIMIT:  rise_r <= cfg_wdata[TW-1:0];
        mvpr_pkg::REG_PULSE_S:     ps_r   <= cfg_wdata[mvpr_pkg::PULSE_S_W-1:0];
        mvpr_pkg::REG_CHECK_S:     cs_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // intervals from the configured seconds
  always_comb begin
    ps_eff = (ps_r == '0) ? mvpr_pkg::PULSE_S_W'(1) : ps_r;
    if (cs_r == '0) begin
      cs_eff = mvpr_pkg::CHECK_S_W'(1);
    end else if (cs_r > mvpr_pkg::CHECK_S_W'(mvpr_pkg::CHECK_MAX_S)) begin
      cs_eff = mvpr_pkg::CHECK_S_W'(mvpr_pkg::CHECK_MAX_S);
    end else begin
      cs_eff = cs_r;
    end
    short_ms   = SW'(ps_eff) * SW'(mvpr_pkg::MS_PER_PULSE_S);
    long_ms    = IW'(cs_eff) * IW'(mvpr_pkg::MS_PER_S);
    short_pick = (IW'(short_ms) < long_ms) ? IW'(short_ms) : long_ms;
  end

  // one regulation step
  always_comb begin
    on    = (in_r.enable_state == mvpr_pkg::EN_ON);
    busy  = in_r.valve_busy;
    ftp_s = $signed({1'b0, ftp_r});
    t_x   = $signed({{2{in_r.measured_temp[mvpr_pkg::TEMP_W-1]}}, in_r.measured_temp});
    tgt_x = $signed({{2{in_r.target_temp[mvpr_pkg::TEMP_W-1]}}, in_r.target_temp});
    prev_x = $signed({{2{prev_r[mvpr_pkg::TEMP_W-1]}}, prev_r});
    h_x   = $signed({{(XW-TW){1'b0}}, band_r});
    r_x   = $signed({{(XW-TW){1'b0}}, rise_r});
    d_x   = t_x - prev_x;
    nd_x  = prev_x - t_x;

    homing_nxt   = homing_r;
    pos_nxt      = pos_r;
    interval_nxt = interval_r;
    cmd_nxt      = mvpr_pkg::CMD_NONE;
    stat_nxt     = (in_r.enable_state == mvpr_pkg::EN_OFF ||
                    in_r.enable_state == mvpr_pkg::EN_ON) ?
                   mvpr_pkg::STAT_OFF : mvpr_pkg::STAT_ERR;
    pct_mode_nxt = PCT_KEEP;
    pnum         = '0;
    pct_from_num = 1'b0;

    if (!homing_r[HW-1] && homing_r != '0) begin
      // homing toward the rest end
      interval_nxt = short_pick;
      if (!busy) begin
        cmd_nxt    = rest_r ? mvpr_pkg::CMD_CLOSE : mvpr_pkg::CMD_OPEN;
        homing_nxt = homing_r - HW'(1);
      end
      pct_from_num = 1'b1;
      pnum = rest_r ? homing_nxt : ftp_s - homing_nxt;
    end else if (homing_r == '0 && on) begin
      interval_nxt = long_ms;
      pos_nxt      = rest_r ? '0 : ftp_r;
      homing_nxt   = '1;
    end else if (homing_r[HW-1] && !on) begin
      // leaving regulation: restart homing
      interval_nxt  = short_pick;
      homing_nxt    = ftp_s;
      pct_mode_nxt  = PCT_FIXED;
    end

    open_ok  = (t_x < tgt_x - h_x) && (pos_nxt < ftp_r) && (d_x < r_x);
    close_ok = (t_x > tgt_x + h_x) && (pos_nxt != '0) && (nd_x < r_x);

    if (homing_nxt[HW-1]) begin
      stat_nxt     = mvpr_pkg::STAT_REG;
      interval_nxt = long_ms;
      if (open_ok) begin
        if (!busy) begin
          cmd_nxt = mvpr_pkg::CMD_OPEN;
          pos_nxt = pos_nxt + TW'(1);
        end
      end else if (close_ok) begin
        if (!busy) begin
          cmd_nxt = mvpr_pkg::CMD_CLOSE;
          pos_nxt = pos_nxt - TW'(1);
        end
      end
      pct_from_num = 1'b1;
      pnum = $signed({1'b0, pos_nxt});
    end

    // percent: saturated ends known now, the rest goes to the divider
    pct_fixed_nxt = mvpr_pkg::PCT_W'(mvpr_pkg::PCT_FULL);
    div_num_nxt   = pnum[TW-1:0];
    if (pct_from_num) begin
      if (ftp_r == '0 || pnum[HW-1] || pnum == '0) begin
        pct_mode_nxt  = PCT_FIXED;
        pct_fixed_nxt = '0;
      end else if (pnum >= ftp_s) begin
        pct_mode_nxt  = PCT_FIXED;
      end else begin
        pct_mode_nxt  = PCT_DIV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      homing_r   <= $signed({1'b0, mvpr_pkg::RST_FULL_TRAVEL});
      pos_r      <= '0;
      prev_r     <= '0;
      pct_held_r <= '0;
      interval_r <= mvpr_pkg::RST_INTERVAL;
    end else begin
      if (cmd.eval) begin
        homing_r   <= homing_nxt;
        pos_r      <= pos_nxt;
        prev_r     <= in_r.measured_temp;
        interval_r <= interval_nxt;
      end
      if (cmd.load_out) begin
        pct_held_r <= pct_final;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
    if (cmd.eval) begin
      cmd_r       <= cmd_nxt;
      stat_r      <= stat_nxt;
      pct_mode_r  <= pct_mode_nxt;
      pct_fixed_r <= pct_fixed_nxt;
      div_num_r   <= div_num_nxt;
    end
    if (cmd.load_out) begin
      out_r.pulse_command    <= cmd_r;
      out_r.open_percent     <= pct_final;
      out_r.point_status     <= stat_r;
      out_r.next_interval_ms <= interval_r;
    end
  end

  mvpr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mvpr_pkg::DIV_N_W'(div_num_r) *
               mvpr_pkg::DIV_N_W'(mvpr_pkg::PCT_FULL)),
    .divisor  (ftp_r),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    case (pct_mode_r)
      PCT_FIXED: pct_final = pct_fixed_r;
      PCT_DIV:   pct_final = quotient[mvpr_pkg::PCT_W-1:0];
      default:   pct_final = pct_held_r;
    endcase
  end

  assign status.div_done = div_done;
  assign out_data        = out_r;

  `AST_IMPLY(a_homing_neg_is_minus_one, homing_r[HW-1], &homing_r,
             "homing count below minus one")
  `AST_IMPLY(a_pct_in_range, cmd.load_out,
             pct_final <= mvpr_pkg::PCT_W'(mvpr_pkg::PCT_FULL), "percent above full")

endmodule

### rtl/core/mvpr_ctrl.sv
// Controller: sequences capture, evaluation, divide and output load.
// Depends on mvpr_pkg for the command and status structs.
`include "assert_macros.svh"

module mvpr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  mvpr_pkg::dp_status_t  status,
  output mvpr_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_START, S_DIV, S_OUT} state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // a new word may replace the one taken at this same edge
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready_r) begin
            state_r    <= S_EVAL;
            in_ready_r <= 1'b0;
          end
        end
        S_EVAL:  state_r <= S_START;
        S_START: state_r <= S_DIV;
        S_DIV: begin
          if (status.div_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // result word waits here until the output register is free
          if (slot_free) begin
            in_ready_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.capture   = (state_r == S_IDLE) && in_valid && in_ready_r;
    cmd.eval      = (state_r == S_EVAL);
    cmd.div_start = (state_r == S_START);
    cmd.load_out  = (state_r == S_OUT) && slot_free;
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  `AST_IMPLY(a_ready_only_idle, in_ready_r, state_r == S_IDLE, "ready outside idle")
  `AST_NEXT(a_load_sets_valid, cmd.load_out, out_valid_r, "loaded word not presented")

endmodule

### rtl/core/mixing_valve_pulse_regulator_top.sv
// Top level of the mixing valve pulse regulator.
// Depends on mvpr_pkg, mvpr_ctrl, mvpr_datapath (which holds mvpr_div).
//
// channel   signals                          word
// input     in_valid / in_ready / in_data    measured, target, enable, busy
// output    out_valid / out_ready / out_data pulse, percent, status, interval
// config    cfg_we / cfg_index / cfg_wdata   one register per write, no wait
//
// A word passes from acceptance to out_valid through capture, evaluation,
// divider start, the bit-serial percent divider and the output load.
// A new word can be taken in the cycle after the previous one is loaded, so
// words are handled one at a time and never overlap.
// A word that finds the output register full waits in the controller.
// Reset is synchronous on rst_n; the block is ready in the first cycle after.
module mixing_valve_pulse_regulator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mvpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mvpr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mvpr_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mvpr_pkg::out_word_t               out_data
);

  mvpr_pkg::ctrl_cmd_t  cmd;
  mvpr_pkg::dp_status_t status;

  mvpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mvpr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

### verif/mixing_valve_pulse_regulator_top_tb.sv
// Self-checking testbench for mixing_valve_pulse_regulator_top: drives check words,
// predicts each result word in-line and compares field by field.
// Depends on mvpr_pkg and the RTL of the regulator only.
`timescale 1ns / 100ps

module mixing_valve_pulse_regulator_top_tb;
  import mvpr_pkg::*;

  // enable codes not named in the package; anything but off/on is a fault
  localparam logic [CODE_W-1:0] EN_FAULT  = 2'd2;
  localparam logic [CODE_W-1:0] EN_UNUSED = 2'd3;

  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 500;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;

  mixing_valve_pulse_regulator_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // register shadow
  int full_travel = int'(RST_FULL_TRAVEL);
  int rest_closed = int'(RST_REST_CLOSED);
  int band        = int'(RST_BAND);
  int rise_limit  = int'(RST_RISE_LIMIT);
  int pulse_s     = int'(RST_PULSE_S);
  int check_s     = int'(RST_CHECK_S);

  // regulator state
  int homing_left = int'(RST_FULL_TRAVEL);
  int valve_pos   = 0;
  int prev_temp   = 0;
  int pct_held    = 0;
  int ivl_held    = int'(RST_INTERVAL);

  in_word_t  check_q[$];
  out_word_t result_q[$];
  out_word_t want;
  int n_pushed   = 0;
  int n_accepted = 0;
  int n_results  = 0;
  int n_errors   = 0;

  // temperature walk used by the random words
  int walk_t   = 0;
  int walk_tgt = 0;

  function automatic int pct_of(int num);
    int v;
    if (full_travel == 0 || num <= 0) return 0;
    v = num * PCT_FULL / full_travel;
    return (v > PCT_FULL) ? PCT_FULL : v;
  endfunction

  function automatic int interval_of(bit short_wanted);
    int ps;
    int cs;
    ps = (pulse_s == 0) ? 1 : pulse_s;
    cs = (check_s == 0) ? 1 : check_s;
    if (cs > CHECK_MAX_S) cs = CHECK_MAX_S;
    if (short_wanted && ps * MS_PER_PULSE_S < cs * MS_PER_S) return ps * MS_PER_PULSE_S;
    return cs * MS_PER_S;
  endfunction

  // one check event: updates the regulator state, returns the result word
  function automatic out_word_t regulate(in_word_t w);
    int t;
    int tgt;
    int d;
    bit on;
    bit busy;
    logic [CODE_W-1:0] stat;
    logic [CODE_W-1:0] cmd;
    out_word_t o;
    t    = int'($signed(w.measured_temp));
    tgt  = int'($signed(w.target_temp));
    on   = (w.enable_state == EN_ON);
    busy = w.valve_busy;
    stat = (w.enable_state == EN_OFF || on) ? STAT_OFF : STAT_ERR;
    cmd  = CMD_NONE;
    if (homing_left > 0) begin
      ivl_held = interval_of(1'b1);
      if (!busy) begin
        cmd = rest_closed ? CMD_CLOSE : CMD_OPEN;
        homing_left--;
      end
      pct_held = rest_closed ? pct_of(homing_left) : pct_of(full_travel - homing_left);
    end else if (homing_left == 0 && on) begin
      ivl_held    = interval_of(1'b0);
      valve_pos   = rest_closed ? 0 : full_travel;
      homing_left = -1;
      pct_held    = pct_of(valve_pos);
    end else if (homing_left < 0 && !on) begin
      // leaving regulation: report fully driven and home again
      ivl_held    = interval_of(1'b1);
      homing_left = full_travel;
      pct_held    = PCT_FULL;
    end
    if (homing_left < 0) begin
      d        = t - prev_temp;
      stat     = STAT_REG;
      ivl_held = interval_of(1'b0);
      if (t < tgt - band && valve_pos < full_travel && d < rise_limit) begin
        if (!busy) begin
          cmd = CMD_OPEN;
          valve_pos++;
        end
      end else if (t > tgt + band && valve_pos > 0 && -d < rise_limit) begin
        if (!busy) begin
          cmd = CMD_CLOSE;
          valve_pos--;
        end
      end
      pct_held = pct_of(valve_pos);
    end
    prev_temp = t;
    o.pulse_command    = cmd;
    o.open_percent     = PCT_W'(pct_held);
    o.point_status     = stat;
    o.next_interval_ms = INTERVAL_W'(ivl_held);
    return o;
  endfunction

  // ---------------- driver ----------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        result_q.push_back(regulate(in_data));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (check_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= check_q.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 200 : 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver ----------------
  int rdy_cnt   = 0;
  int rdy_mode  = 0;
  int hold_left = 0;
  int hold_idx  = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      rdy_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_idx < 2 && n_results >= ((hold_idx == 0) ? 200 : 700)) begin
        // long back-pressure while the sender keeps offering words
        hold_idx++;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        if (rdy_cnt % 64 == 0) rdy_mode = $urandom_range(0, 3);
        case (rdy_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 9) != 0);
          default: out_ready <= (rdy_cnt % 4 == 0);
        endcase
      end
    end
  end

  // ---------------- monitor ----------------
  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (result_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected output word, expected none actual %p", $time, out_data);
      end else begin
        want = result_q.pop_front();
        check_field("pulse_command", int'(want.pulse_command),
                    int'(out_data.pulse_command));
        check_field("open_percent", int'(want.open_percent),
                    int'(out_data.open_percent));
        check_field("point_status", int'(want.point_status),
                    int'(out_data.point_status));
        check_field("next_interval_ms", int'(want.next_interval_ms),
                    int'(out_data.next_interval_ms));
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic push_word(int m, int t, logic [CODE_W-1:0] en, bit busy);
    in_word_t w;
    w.measured_temp = TEMP_W'(m);
    w.target_temp   = TEMP_W'(t);
    w.enable_state  = en;
    w.valve_busy    = busy;
    check_q.push_back(w);
    n_pushed++;
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    case (idx)
      REG_FULL_TRAVEL: full_travel = val & 'h3FF;
      REG_REST_CLOSED: rest_closed = val & 'h1;
      REG_BAND:        band        = val & 'h3FF;
      REG_RISE_LIMIT:  rise_limit  = val & 'h3FF;
      REG_PULSE_S:     pulse_s     = val & 'hFF;
      REG_CHECK_S:     check_s     = val & 'hFFF;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (n_accepted != n_pushed || result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly a slow walk around the target so the band and rise checks get
  // exercised; some words are full-range noise or leave regulation
  task automatic push_random(bit keep_on);
    int r;
    int lim;
    int span;
    int step;
    logic [CODE_W-1:0] en;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      push_word($urandom, $urandom, keep_on ? EN_ON : CODE_W'($urandom_range(0, 3)),
                ($urandom_range(0, 1) == 1));
    end else begin
      lim  = (rise_limit > 40) ? 40 : rise_limit;
      span = band * 2 + 10;
      if ($urandom_range(0, 49) == 0) walk_tgt = $urandom_range(0, 65535) - 32768;
      if (r < 15) walk_t = walk_tgt + $urandom_range(0, 2 * span) - span;
      step = $urandom_range(0, 2 * lim + 4) - (lim + 2);
      if (walk_t > walk_tgt + span && step > 0) step = -step;
      if (walk_t < walk_tgt - span && step < 0) step = -step;
      walk_t += step;
      if (walk_t > 32767) walk_t = 32767;
      if (walk_t < -32768) walk_t = -32768;
      if (keep_on || r < 90) en = EN_ON;
      else if (r < 94) en = EN_OFF;
      else if (r < 97) en = EN_FAULT;
      else en = EN_UNUSED;
      push_word(walk_t, walk_tgt, en, $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic run_phase(int ft, int rc, int bd, int rl, int ps, int cs, int n, bit keep_on);
    set_reg(REG_FULL_TRAVEL, ft);
    set_reg(REG_REST_CLOSED, rc);
    set_reg(REG_BAND, bd);
    set_reg(REG_RISE_LIMIT, rl);
    set_reg(REG_PULSE_S, ps);
    set_reg(REG_CHECK_S, cs);
    @(posedge clk);
    cfg_we <= 1'b0;
    for (int i = 0; i < n; i++) push_random(keep_on);
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // homing after reset: field extremes, every enable code, busy refusals
    push_word(32767, -32768, EN_OFF, 1'b0);
    push_word(-32768, 32767, EN_ON, 1'b0);
    push_word(0, 0, EN_FAULT, 1'b1);
    push_word(-1, -1, EN_UNUSED, 1'b0);
    push_word(21845, -21846, EN_ON, 1'b1);
    push_word(-21846, 21845, EN_FAULT, 1'b0);
    push_word(32767, 32767, EN_OFF, 1'b1);
    push_word(-32768, -32768, EN_UNUSED, 1'b1);
    // finish homing, then take over at the closed end
    for (int i = 0; i < 101; i++) push_word(0, 0, EN_ON, 1'b0);
    push_word(-20, 0, EN_ON, 1'b0);          // below band, falling: open
    push_word(-18, 0, EN_ON, 1'b0);          // small rise: open
    push_word(-14, 0, EN_ON, 1'b0);          // rise too fast: hold
    push_word(-15, 0, EN_ON, 1'b1);          // busy: refused
    push_word(-15, 0, EN_ON, 1'b0);
    push_word(5, 0, EN_ON, 1'b0);            // inside band
    push_word(30, 0, EN_ON, 1'b0);           // above band: close
    push_word(32767, -32768, EN_ON, 1'b0);   // differences beyond 16 bits
    push_word(-32768, 32767, EN_ON, 1'b0);
    push_word(0, 0, EN_FAULT, 1'b0);         // leave regulation
    push_word(0, 0, EN_UNUSED, 1'b0);
    push_word(0, 0, EN_OFF, 1'b0);
    drain();

    run_phase(8, 1, 2, 3, 1, 60, 150, 1'b0);
    run_phase(1, 0, 0, 0, 255, 1, 100, 1'b0);
    run_phase(5, 1, 1023, 1023, 0, 0, 100, 1'b0);
    run_phase(20, 0, 5, 10, 2, 4095, 150, 1'b0);
    // full stroke at the open end, kept on so it does not re-home 1023 pulses
    run_phase(1023, 0, 3, 50, 10, 3600, 60, 1'b1);
    // position now beyond the travel: open blocked, percent reads zero
    run_phase(0, 1, 4, 8, 3, 10, 60, 1'b0);
    run_phase(12, 1, 6, 5, 7, 20, 100, 1'b0);
    run_phase(100, 1, 10, 3, 1, 60, 110, 1'b0);

    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
